// ----- src/fgn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg
// shared types, register codes and the permutation table of the noise block
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int STEP_W   = 24;
  localparam int LEVEL_W  = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int LANE_DEPTH = 6;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65536;
  localparam logic [LEVEL_W-1:0] BASE_RESET  = 16'd128;
  localparam logic [LEVEL_W-1:0] RANGE_RESET = 16'd128;

  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_BASE  = 2'd1,
    REG_RANGE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        [STEP_W-1:0]  coord_step;
    logic signed [LEVEL_W-1:0] level_base;
    logic signed [LEVEL_W-1:0] level_range;
  } cfg_t;

  localparam logic [7:0] PERM_ROM [0:255] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,
    8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,
    8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190,
    8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177,
    8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136,
    8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,
    8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,
    8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161,
    8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
    8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126,
    8'd255, 8'd82,  8'd85,  8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,
    8'd58,  8'd17,  8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,  8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,   8'd129, 8'd22,  8'd39,  8'd253,
    8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241, 8'd81,  8'd51,
    8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107, 8'd49,  8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121,
    8'd50,  8'd45,  8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141, 8'd128, 8'd195,
    8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

// ----- src/fgn_pixel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pixel_if
// pixel coordinate channel: valid/ready with column and row
// ----------------------------------------------------------------------------
interface fgn_pixel_if #(
  parameter int INDEX_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] column;
  logic [INDEX_BITS-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

// ----- src/fgn_level_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_level_if
// luminance channel: valid/ready with one level byte
// ----------------------------------------------------------------------------
interface fgn_level_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ----- src/fgn_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_cfg
// apb register file: coordinate step, level base and level range
// ----------------------------------------------------------------------------
module fgn_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fgn_pkg::PADDR_W-1:0]  paddr,
  input  logic [fgn_pkg::PDATA_W-1:0]  pwdata,
  output logic [fgn_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output fgn_pkg::cfg_t                cfg_o
);

  fgn_pkg::cfg_t     cfg_q, cfg_d;
  fgn_pkg::reg_idx_e idx;
  logic              wr;

  assign idx    = fgn_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        fgn_pkg::REG_STEP:  cfg_d.coord_step  = pwdata[fgn_pkg::STEP_W-1:0];
        fgn_pkg::REG_BASE:  cfg_d.level_base  = pwdata[fgn_pkg::LEVEL_W-1:0];
        fgn_pkg::REG_RANGE: cfg_d.level_range = pwdata[fgn_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fgn_pkg::REG_STEP:
        prdata = {{(fgn_pkg::PDATA_W-fgn_pkg::STEP_W){1'b0}}, cfg_q.coord_step};
      fgn_pkg::REG_BASE:
        prdata = {{(fgn_pkg::PDATA_W-fgn_pkg::LEVEL_W){cfg_q.level_base[15]}},
                  cfg_q.level_base};
      fgn_pkg::REG_RANGE:
        prdata = {{(fgn_pkg::PDATA_W-fgn_pkg::LEVEL_W){cfg_q.level_range[15]}},
                  cfg_q.level_range};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coord_step  <= fgn_pkg::STEP_RESET;
      cfg_q.level_base  <= fgn_pkg::BASE_RESET;
      cfg_q.level_range <= fgn_pkg::RANGE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- src/fgn_fade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_fade
// three-stage quintic fade curve 6f^5 - 15f^4 + 10f^3 in fixed point
// ----------------------------------------------------------------------------
module fgn_fade #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [FRACTION_BITS-1:0] f_i,
  output logic [FRACTION_BITS:0]   u_o
);

  localparam int F = FRACTION_BITS;
  localparam logic [F+3:0] FIFTEEN_S = {4'd15, {F{1'b0}}};
  localparam logic [F+3:0] TEN_S     = {4'd10, {F{1'b0}}};

  logic [F+3:0]   six_f, w;
  logic [2*F+3:0] t_full, u_full;
  logic [2*F-1:0] ff_full, c_full;

  logic [F-1:0]   ff_q, f_q, c_q;
  logic [F+3:0]   t_q, qv_q;
  logic [F:0]     u_q;

  // stage a: f*f and (15 - 6f)*f
  assign six_f   = {2'b00, f_i, 2'b00} + {3'b000, f_i, 1'b0};
  assign w       = FIFTEEN_S - six_f;
  assign t_full  = w * {4'b0000, f_i};
  assign ff_full = f_i * f_i;
  // stage b: f^3 and q
  assign c_full  = ff_q * f_q;
  // stage c: f^3 * q
  assign u_full  = {4'b0000, c_q} * qv_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ff_q <= ff_full[2*F-1:F];
      t_q  <= t_full[2*F+3:F];
      f_q  <= f_i;
      c_q  <= c_full[2*F-1:F];
      qv_q <= TEN_S - t_q;
      u_q  <= u_full[2*F:F];
    end
  end

  assign u_o = u_q;

endmodule

// ----- src/fgn_octave.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_octave
// one octave of 2d gradient noise: hashing, fade, gradients and lerps
// ----------------------------------------------------------------------------
module fgn_octave #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [7:0]                      xi_i,
  input  logic [7:0]                      yi_i,
  input  logic [FRACTION_BITS-1:0]        fx_i,
  input  logic [FRACTION_BITS-1:0]        fy_i,
  output logic signed [FRACTION_BITS+2:0] n_o
);

  localparam int F  = FRACTION_BITS;
  localparam int GW = F + 3;
  localparam logic signed [GW-1:0] ONE = {3'b001, {F{1'b0}}};

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [GW-1:0] dx,
                                                input logic signed [GW-1:0] dy);
    logic signed [GW-1:0] gu, gv;
    gu = h[3] ? dy : dx;
    if (h[3:2] == 2'b00) gv = dy;
    else if (h[3:2] == 2'b11 && !h[0]) gv = dx;
    else gv = '0;
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  // a + floor(t * (b - a) / S)
  function automatic logic signed [GW-1:0] lerp(input logic [F:0] t,
                                                input logic signed [GW-1:0] a,
                                                input logic signed [GW-1:0] b);
    logic signed [GW:0]      d;
    logic signed [GW+F+2:0]  p, sh;
    d  = {b[GW-1], b} - {a[GW-1], a};
    p  = $signed({1'b0, t}) * d;
    sh = p >>> F;
    return a + sh[GW-1:0];
  endfunction

  logic [F:0] u_w, v_w;

  // stage 1: x hashes
  logic [7:0]   s1_hx0_q, s1_hx1_q, s1_yi_q;
  logic [F-1:0] s1_fx_q, s1_fy_q;
  // stage 2: corner hashes
  logic [7:0]   s2_h_q [4];
  logic [F-1:0] s2_fx_q, s2_fy_q;
  // stage 3: gradient codes
  logic [3:0]   s3_code_q [4];
  logic [F-1:0] s3_fx_q, s3_fy_q;
  // stage 4: gradients
  logic signed [GW-1:0] s4_g_q [4];
  logic [F:0]           s4_u_q, s4_v_q;
  // stage 5: inner lerps
  logic signed [GW-1:0] s5_x1_q, s5_x2_q;
  logic [F:0]           s5_v_q;
  // stage 6: noise value
  logic signed [GW-1:0] s6_n_q;

  logic [7:0] a_w, b_w;
  logic signed [GW-1:0] dx0, dx1, dy0, dy1;

  assign a_w = s1_hx0_q + s1_yi_q;
  assign b_w = s1_hx1_q + s1_yi_q;
  assign dx0 = {3'b000, s3_fx_q};
  assign dy0 = {3'b000, s3_fy_q};
  assign dx1 = dx0 - ONE;
  assign dy1 = dy0 - ONE;

  fgn_fade #(.FRACTION_BITS(F)) u_fade_x (.clk_i, .en_i, .f_i(fx_i), .u_o(u_w));
  fgn_fade #(.FRACTION_BITS(F)) u_fade_y (.clk_i, .en_i, .f_i(fy_i), .u_o(v_w));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hx0_q <= fgn_pkg::PERM_ROM[xi_i];
      s1_hx1_q <= fgn_pkg::PERM_ROM[xi_i + 8'd1];
      s1_yi_q  <= yi_i;
      s1_fx_q  <= fx_i;
      s1_fy_q  <= fy_i;

      s2_h_q[0] <= fgn_pkg::PERM_ROM[a_w];
      s2_h_q[1] <= fgn_pkg::PERM_ROM[b_w];
      s2_h_q[2] <= fgn_pkg::PERM_ROM[a_w + 8'd1];
      s2_h_q[3] <= fgn_pkg::PERM_ROM[b_w + 8'd1];
      s2_fx_q   <= s1_fx_q;
      s2_fy_q   <= s1_fy_q;

      for (int k = 0; k < 4; k++) begin
        s3_code_q[k] <= fgn_pkg::PERM_ROM[s2_h_q[k]][3:0];
      end
      s3_fx_q <= s2_fx_q;
      s3_fy_q <= s2_fy_q;

      // corners: 00, 10, 01, 11
      s4_g_q[0] <= grad(s3_code_q[0], dx0, dy0);
      s4_g_q[1] <= grad(s3_code_q[1], dx1, dy0);
      s4_g_q[2] <= grad(s3_code_q[2], dx0, dy1);
      s4_g_q[3] <= grad(s3_code_q[3], dx1, dy1);
      s4_u_q    <= u_w;
      s4_v_q    <= v_w;

      s5_x1_q <= lerp(s4_u_q, s4_g_q[0], s4_g_q[1]);
      s5_x2_q <= lerp(s4_u_q, s4_g_q[2], s4_g_q[3]);
      s5_v_q  <= s4_v_q;

      s6_n_q <= lerp(s5_v_q, s5_x1_q, s5_x2_q);
    end
  end

  assign n_o = s6_n_q;

endmodule

// ----- src/fractal_gradient_noise_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_pixel
// streaming fractal gradient noise generator, one luminance byte per pixel
// ----------------------------------------------------------------------------
// usage
//   pix_i carries one pixel (column, row) per transfer; lvl_o returns its
//   luminance byte, one transfer per input transfer, in the same order
//   registers (apb, pready always high): 0x0 coord_step, 0x4 level_base,
//   0x8 level_range; write them only while no pixel is in flight
// pipeline
//   stages from input transfer to result valid: 1 coordinate multiply,
//   6 octave stages (3 permutation lookups in parallel with the 3-stage
//   fade multiplier chain, gradients, two lerp levels), octave sum, gain
//   multiply, offset and clamp; all octave lanes run side by side, so one
//   pixel is taken every cycle while the result is not stalled
// reset
//   clears the valid bits of every stage and loads the register defaults
//   (step 1.0, base 128, range 128)
// backpressure
//   when the result waits and lvl_o.ready is low the whole pipeline holds;
//   pix_i.ready drops in the same cycle, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module fractal_gradient_noise_pixel #(
  parameter int INDEX_BITS    = 12,
  parameter int OCTAVE_COUNT  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fgn_pixel_if.sink                   pix_i,
  fgn_level_if.source                 lvl_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fgn_pkg::PADDR_W-1:0] paddr,
  input  logic [fgn_pkg::PDATA_W-1:0] pwdata,
  output logic [fgn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int F     = FRACTION_BITS;
  localparam int XW    = INDEX_BITS + fgn_pkg::STEP_W;  // lattice coordinate
  localparam int CW    = XW + F + 8;                    // padded for octave shifts
  localparam int GW    = F + 3;                         // noise value
  localparam int SW    = GW + OCTAVE_COUNT;             // octave sum
  localparam int PW    = SW + fgn_pkg::LEVEL_W;         // scaled sum
  localparam int SHIFT = F + OCTAVE_COUNT - 1;
  localparam int DEPTH = fgn_pkg::LANE_DEPTH + 4;

  fgn_pkg::cfg_t cfg;

  fgn_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // global advance: the pipeline moves whenever the output slot is free
  logic             en;
  logic [DEPTH-1:0] v_q;

  assign en          = !v_q[DEPTH-1] || lvl_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], pix_i.valid};
    end
  end

  // stage 1: lattice coordinates
  logic [XW-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= pix_i.column * cfg.coord_step;
      y0_q <= pix_i.row * cfg.coord_step;
    end
  end

  // octave lanes: octave o samples at coordinate * 2^o
  logic signed [GW-1:0] n_w [OCTAVE_COUNT];

  for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
    logic [CW-1:0] xs, ys;
    assign xs = {{(F + 8){1'b0}}, x0_q} << o;
    assign ys = {{(F + 8){1'b0}}, y0_q} << o;

    fgn_octave #(.FRACTION_BITS(F)) u_oct (
      .clk_i,
      .en_i (en),
      .xi_i (xs[F+7:F]),
      .yi_i (ys[F+7:F]),
      .fx_i (xs[F-1:0]),
      .fy_i (ys[F-1:0]),
      .n_o  (n_w[o])
    );
  end

  // octave sum: weight halves per octave, kept exact with extra fraction bits
  logic signed [SW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int o = 0; o < OCTAVE_COUNT; o++) begin
      sum_d = sum_d + (SW'(n_w[o]) <<< (OCTAVE_COUNT - 1 - o));
    end
  end

  // gain
  logic signed [PW-1:0] prod_q;

  // truncate toward zero, add base, clamp to a byte
  logic signed [PW-1:0] mag, mq, q, lv;
  logic [7:0]           level_d, level_q;

  always_comb begin
    mag = prod_q[PW-1] ? -prod_q : prod_q;
    mq  = mag >>> SHIFT;
    q   = prod_q[PW-1] ? -mq : mq;
    lv  = PW'(cfg.level_base) + q;
    if (lv < 0) begin
      level_d = 8'd0;
    end else if (lv > PW'(255)) begin
      level_d = 8'd255;
    end else begin
      level_d = lv[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= sum_d;
      prod_q  <= cfg.level_range * sum_q;
      level_q <= level_d;
    end
  end

  assign lvl_o.valid = v_q[DEPTH-1];
  assign lvl_o.level = level_q;

`ifndef SYNTHESIS
  // a stalled result freezes every stage's valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_o.valid && !lvl_o.ready) |=> $stable(v_q))
    else $error("pipeline moved while result stalled");

  // zero gain leaves nothing of the noise in the scaled sum
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cfg.level_range == '0) |=> (prod_q == '0))
    else $error("nonzero product with zero gain");

  // base register takes the written data
  a_base_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == 2'(fgn_pkg::REG_BASE))
      |=> (cfg.level_base == $signed($past(pwdata[fgn_pkg::LEVEL_W-1:0]))))
    else $error("level_base write lost");
`endif

endmodule
